// ===== hdl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants, types and width helpers for the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MEAS_W        = 16;
  localparam int EST_W         = 16;
  localparam int STATE_W       = 32;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CHUNK_W       = 16;
  localparam int CHUNK_LG      = 4;
  localparam int CHUNK_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd1;

  localparam logic [CFG_W-1:0] NOISE_RST = 32'h0001_0000;

  // Magnitude width of the innovation meas*2^F - X
  function automatic int mag_width(input int f);
    int a;
    a = (15 + f > 31) ? 15 + f : 31;
    return a + 2;
  endfunction

  function automatic int mag_chunks(input int f);
    return (mag_width(f) + CHUNK_W - 1) / CHUNK_W;
  endfunction

  localparam int COV_CHUNKS = STATE_W / CHUNK_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PM,
    ST_DEN,
    ST_DIV,
    ST_MULX,
    ST_MULP,
    ST_DRAIN,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                   load;
    logic                   pm;
    logic                   den;
    logic                   div;
    logic                   mul;
    logic                   mul_cov;
    logic [CHUNK_IDX_W-1:0] chunk;
    logic                   upd;
    logic                   out_load;
  } cmd_t;

endpackage

// ===== hdl/skf_ctrl.sv =====
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer: steps the datapath through prediction, gain division,
// chunked multiplies, update and output load; owns the handshakes.
// ----------------------------------------------------------------------------
module skf_ctrl #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output skf_pkg::cmd_t cmd
);

  localparam int NX    = skf_pkg::mag_chunks(FRAC_BITS);
  localparam int NP    = skf_pkg::COV_CHUNKS;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  skf_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skf_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      skf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = skf_pkg::ST_PM;
        end
      end
      skf_pkg::ST_PM: begin
        state_nxt = skf_pkg::ST_DEN;
      end
      skf_pkg::ST_DEN: begin
        state_nxt = skf_pkg::ST_DIV;
        cnt_nxt   = '0;
      end
      skf_pkg::ST_DIV: begin
        if (cnt_r == CNT_W'(FRAC_BITS)) begin
          state_nxt = skf_pkg::ST_MULX;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      skf_pkg::ST_MULX: begin
        if (cnt_r == CNT_W'(NX - 1)) begin
          state_nxt = skf_pkg::ST_MULP;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      skf_pkg::ST_MULP: begin
        if (cnt_r == CNT_W'(NP - 1)) begin
          state_nxt = skf_pkg::ST_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      skf_pkg::ST_DRAIN: begin
        state_nxt = skf_pkg::ST_UPD;
      end
      skf_pkg::ST_UPD: begin
        state_nxt = skf_pkg::ST_OUT;
      end
      skf_pkg::ST_OUT: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          state_nxt = skf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = skf_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.chunk    = cnt_r[skf_pkg::CHUNK_IDX_W-1:0];
    in_stall     = 1'b1;
    case (state_r)
      skf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      skf_pkg::ST_PM:   cmd.pm  = 1'b1;
      skf_pkg::ST_DEN:  cmd.den = 1'b1;
      skf_pkg::ST_DIV:  cmd.div = 1'b1;
      skf_pkg::ST_MULX: cmd.mul = 1'b1;
      skf_pkg::ST_MULP: begin
        cmd.mul     = 1'b1;
        cmd.mul_cov = 1'b1;
      end
      skf_pkg::ST_DRAIN: begin
      end
      skf_pkg::ST_UPD:  cmd.upd = 1'b1;
      skf_pkg::ST_OUT:  cmd.out_load = !out_valid_r || !out_stall;
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a transfer is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("stalled result overwritten");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.pm, cmd.den, cmd.div, cmd.mul, cmd.upd, cmd.out_load}))
    else $error("datapath commands overlap");

  a_load_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

// ===== hdl/skf_dp.sv =====
// ----------------------------------------------------------------------------
// skf_dp
// Datapath: noise registers, estimate and covariance state, restoring
// divider for the gain, shared chunked multiplier with two accumulators,
// update with saturation and the rounded output register.
// ----------------------------------------------------------------------------
module skf_dp #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  skf_pkg::cmd_t                       cmd,
  input  logic signed [skf_pkg::MEAS_W-1:0]   in_measurement,
  input  logic                                cfg_we,
  input  logic        [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [skf_pkg::CFG_W-1:0]    cfg_wdata,
  output logic signed [skf_pkg::EST_W-1:0]    out_estimate
);

  localparam int SW     = skf_pkg::STATE_W;
  localparam int CW     = skf_pkg::CHUNK_W;
  localparam int GW     = FRAC_BITS + 1;
  localparam int MAG_W  = skf_pkg::mag_width(FRAC_BITS);
  localparam int INN_W  = MAG_W + 1;
  localparam int NX     = skf_pkg::mag_chunks(FRAC_BITS);
  localparam int MAGP_W = NX * CW;
  localparam int PROD_W = GW + CW;
  localparam int ACCX_W = GW + MAGP_W;
  localparam int ACCP_W = GW + SW;
  localparam int DW     = ACCX_W - FRAC_BITS;
  localparam int SUM_W  = DW + 2;
  localparam int DEN_W  = SW + 1;
  localparam int REM_W  = SW + 2;
  localparam int RND_W  = SW + 1;

  localparam logic [GW-1:0]     ONE    = GW'(1) << FRAC_BITS;
  localparam logic [ACCX_W-1:0] HALF_X = ACCX_W'(1) << (FRAC_BITS - 1);
  localparam logic [ACCP_W-1:0] HALF_P = ACCP_W'(1) << (FRAC_BITS - 1);
  localparam logic [RND_W-1:0]  HALF_R = RND_W'(1) << (FRAC_BITS - 1);

  logic        [SW-1:0]    q_r, r_r, p_r, pm_r;
  logic signed [SW-1:0]    x_r, xn_r;
  logic signed [skf_pkg::MEAS_W-1:0] meas_r;
  logic        [DEN_W-1:0] den_r;
  logic        [REM_W-1:0] rem_r;
  logic        [GW-1:0]    gain_r;
  logic signed [INN_W-1:0] inn_r;
  logic        [MAGP_W-1:0] mag_r;
  logic                    neg_r;
  logic        [PROD_W-1:0] prod_r;
  logic                    prod_vld_r, prod_cov_r;
  logic [skf_pkg::CHUNK_IDX_W-1:0] prod_k_r;
  logic        [ACCX_W-1:0] accx_r;
  logic        [ACCP_W-1:0] accp_r;
  logic signed [skf_pkg::EST_W-1:0] est_r;

  // combinational helpers
  logic [SW:0]             pq_sum;
  logic [SW-1:0]           pm_nxt;
  logic signed [INN_W-1:0] inn_nxt;
  logic [INN_W-1:0]        inn_abs;
  logic                    div_take;
  logic [REM_W-1:0]        rem_nxt;
  logic [GW-1:0]           op_a;
  logic [CW-1:0]           op_b;
  logic [skf_pkg::CHUNK_LG+skf_pkg::CHUNK_IDX_W-1:0] sh_cmd, sh_acc;
  logic signed [SUM_W-1:0] dmag, xsum;
  logic signed [SW-1:0]    x_nxt;
  logic signed [RND_W-1:0] rnd, rsh;
  logic signed [skf_pkg::EST_W-1:0] est_nxt;

  always_comb begin
    pq_sum  = {1'b0, p_r} + {1'b0, q_r};
    pm_nxt  = pq_sum[SW] ? '1 : pq_sum[SW-1:0];
    inn_nxt = (INN_W'(meas_r) <<< FRAC_BITS) - INN_W'(x_r);
    inn_abs = inn_r[INN_W-1] ? -inn_r : inn_r;

    // a zero divisor gives a zero gain
    div_take = (den_r != '0) && (rem_r >= REM_W'(den_r));
    rem_nxt  = (div_take ? rem_r - REM_W'(den_r) : rem_r) << 1;

    sh_cmd = {cmd.chunk, skf_pkg::CHUNK_LG'(0)};
    sh_acc = {prod_k_r, skf_pkg::CHUNK_LG'(0)};
    op_a   = cmd.mul_cov ? ONE - gain_r : gain_r;
    op_b   = cmd.mul_cov ? CW'(pm_r >> sh_cmd) : CW'(mag_r >> sh_cmd);

    dmag  = SUM_W'(accx_r >> FRAC_BITS);
    xsum  = SUM_W'(x_r) + (neg_r ? -dmag : dmag);
    if (xsum[SUM_W-1:SW-1] != '0 && xsum[SUM_W-1:SW-1] != '1) begin
      x_nxt = xsum[SUM_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      x_nxt = xsum[SW-1:0];
    end

    rnd = RND_W'(xn_r) + HALF_R;
    rsh = rnd >>> FRAC_BITS;
    if (rsh[RND_W-1:skf_pkg::EST_W-1] != '0 && rsh[RND_W-1:skf_pkg::EST_W-1] != '1) begin
      est_nxt = rsh[RND_W-1] ? {1'b1, {(skf_pkg::EST_W-1){1'b0}}}
                             : {1'b0, {(skf_pkg::EST_W-1){1'b1}}};
    end else begin
      est_nxt = rsh[skf_pkg::EST_W-1:0];
    end
  end

  // configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= skf_pkg::NOISE_RST;
      r_r <= skf_pkg::NOISE_RST;
      x_r <= '0;
      p_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        skf_pkg::CFG_PROC_NOISE: begin
          q_r <= cfg_wdata;
          x_r <= '0;
          p_r <= '0;
        end
        skf_pkg::CFG_MEAS_NOISE: begin
          r_r <= cfg_wdata;
          x_r <= '0;
          p_r <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.upd) begin
      x_r <= x_nxt;
      p_r <= SW'(accp_r >> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas_r <= in_measurement;
    end
    if (cmd.pm) begin
      pm_r  <= pm_nxt;
      inn_r <= inn_nxt;
    end
    if (cmd.den) begin
      den_r  <= {1'b0, pm_r} + {1'b0, r_r};
      rem_r  <= REM_W'(pm_r);
      gain_r <= '0;
      mag_r  <= MAGP_W'(inn_abs);
      neg_r  <= inn_r[INN_W-1];
      // rounding half folded into the accumulators up front
      accx_r <= HALF_X;
      accp_r <= HALF_P;
    end
    if (cmd.div) begin
      rem_r  <= rem_nxt;
      gain_r <= {gain_r[GW-2:0], div_take};
    end
    if (cmd.mul) begin
      prod_r     <= PROD_W'(op_a) * PROD_W'(op_b);
      prod_cov_r <= cmd.mul_cov;
      prod_k_r   <= cmd.chunk;
    end
    if (prod_vld_r) begin
      if (prod_cov_r) begin
        accp_r <= accp_r + (ACCP_W'(prod_r) << sh_acc);
      end else begin
        accx_r <= accx_r + (ACCX_W'(prod_r) << sh_acc);
      end
    end
    if (cmd.upd) begin
      xn_r <= x_nxt;
    end
    if (cmd.out_load) begin
      est_r <= est_nxt;
    end
  end

  assign out_estimate = est_r;

`ifndef SYNTH
  a_gain_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> (gain_r <= ONE))
    else $error("gain above one");

  a_cov_not_grown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> (p_r <= $past(pm_r)))
    else $error("covariance grew in update");
`endif

endmodule

// ===== hdl/scalar_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional fixed-point Kalman filter, unit transition and observation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one signed integer measurement
//   per transfer; output channel out_valid/out_stall returns one rounded,
//   saturated signed estimate per measurement, in order.
//   The cfg_ port writes process noise Q (index 0) or measurement noise R
//   (index 1), Q16.16 by default; any such write also clears the estimate
//   and covariance. Write only while the filter is idle.
//   One item is worked at a time; a new item is taken only after the
//   previous result has been loaded into the output register. The gain
//   divider makes one quotient bit per cycle (FRAC_BITS + 1 bits) and the
//   shared 16-bit-chunk multiplier forms five partial products at the default.
//   The output register holds a result while out_stall is high; the next
//   input is still accepted and worked, and only its final load waits.
//   Reset (rst_n low, synchronous) sets Q = R = 1.0, clears estimate and
//   covariance and empties the output register.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [skf_pkg::MEAS_W-1:0]    in_measurement,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [skf_pkg::EST_W-1:0]     out_estimate,
  input  logic                                 cfg_we,
  input  logic        [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [skf_pkg::CFG_W-1:0]     cfg_wdata
);

  skf_pkg::cmd_t cmd;

  skf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  skf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_measurement (in_measurement),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_estimate   (out_estimate)
  );

endmodule

// ===== tb/skf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_checker
// Watches the measurement, estimate and register ports of the scalar Kalman
// filter, tracks Q, R, estimate and covariance on its own, and compares
// every estimate transfer with the oldest predicted estimate.
// ----------------------------------------------------------------------------
module skf_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [skf_pkg::MEAS_W-1:0]    in_measurement,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [skf_pkg::EST_W-1:0]     out_estimate,
  input  logic                                 cfg_we,
  input  logic        [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [skf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                                 end_of_test,
  output int                                   fail_count
);

  localparam int F = skf_pkg::FRAC_BITS_DEF;

  localparam logic        [63:0] ONE_U  = 64'd1 << F;
  localparam logic        [63:0] HALF_U = 64'd1 << (F - 1);
  localparam logic signed [63:0] HALF_S = 64'sd1 <<< (F - 1);
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] EST_MAX = 64'sd32767;
  localparam logic signed [63:0] EST_MIN = -64'sd32768;

  logic        [31:0] q_noise;
  logic        [31:0] r_noise;
  logic        [31:0] covariance;
  logic signed [31:0] estimate_fx;
  logic signed [skf_pkg::EST_W-1:0] pending_estimates[$];
  logic end_seen;

  initial fail_count = 0;

  // One filter step: advance estimate and covariance, return rounded sample.
  task automatic kalman_update(input  logic signed [skf_pkg::MEAS_W-1:0] meas,
                               output logic signed [skf_pkg::EST_W-1:0]  est_out);
    logic        [63:0] pm, den, gain, mag, prod, pn;
    logic signed [63:0] meas_w, est_w, inn, delta, xn, rnd;
    logic               neg;
    pm = {32'd0, covariance} + {32'd0, q_noise};
    if (pm > 64'hFFFF_FFFF) pm = 64'hFFFF_FFFF;
    den = pm + {32'd0, r_noise};
    gain = (den != 64'd0) ? (pm << F) / den : 64'd0;
    meas_w = meas;
    est_w = estimate_fx;
    inn = (meas_w <<< F) - est_w;
    neg = inn < 0;
    mag = neg ? -inn : inn;
    prod = (gain * mag + HALF_U) >> F;
    delta = neg ? -$signed(prod) : $signed(prod);
    xn = est_w + delta;
    if (xn > S32_MAX) xn = S32_MAX;
    if (xn < S32_MIN) xn = S32_MIN;
    estimate_fx = xn[31:0];
    pn = ((ONE_U - gain) * pm + HALF_U) >> F;
    covariance = pn[31:0];
    // arithmetic shift floors, so a half rounds toward plus infinity
    rnd = (xn + HALF_S) >>> F;
    if (rnd > EST_MAX) rnd = EST_MAX;
    if (rnd < EST_MIN) rnd = EST_MIN;
    est_out = rnd[skf_pkg::EST_W-1:0];
  endtask

  always @(posedge clk) begin : track
    logic signed [skf_pkg::EST_W-1:0] want;
    if (!rst_n) begin
      q_noise = skf_pkg::NOISE_RST;
      r_noise = skf_pkg::NOISE_RST;
      covariance = '0;
      estimate_fx = '0;
      pending_estimates.delete();
      end_seen = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          skf_pkg::CFG_PROC_NOISE: begin
            q_noise = cfg_wdata;
            covariance = '0;
            estimate_fx = '0;
          end
          skf_pkg::CFG_MEAS_NOISE: begin
            r_noise = cfg_wdata;
            covariance = '0;
            estimate_fx = '0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        kalman_update(in_measurement, want);
        pending_estimates.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_estimates.size() == 0) begin
          $error("estimate: expected none, actual %0d", out_estimate);
          fail_count++;
        end else begin
          want = pending_estimates.pop_front();
          if (out_estimate !== want) begin
            $error("estimate: expected %0d, actual %0d", want, out_estimate);
            fail_count++;
          end
        end
      end
      if (end_of_test && !end_seen) begin
        end_seen = 1'b1;
        if (pending_estimates.size() != 0) begin
          $error("estimate: %0d expected transfers never arrived",
                 pending_estimates.size());
          fail_count++;
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives measurements and noise settings into the scalar Kalman filter under
// random sender gaps and receiver stalls; skf_checker judges every estimate.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int PHASE_ITEMS   = 57;
  localparam int HOLD_CYCLES   = 400;
  localparam logic [skf_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [skf_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [skf_pkg::MEAS_W-1:0] in_measurement = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [skf_pkg::EST_W-1:0] out_estimate;
  logic cfg_we = 1'b0;
  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [skf_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic end_of_test = 1'b0;
  int fail_count;

  int n_sent = 0;
  int n_recv = 0;
  int n_settings = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_left = 0;
  int holds_done = 0;
  int cycles = 0;
  logic signed [skf_pkg::MEAS_W-1:0] last_meas = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  scalar_kalman_filter u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_measurement (in_measurement),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_estimate   (out_estimate),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  skf_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_measurement (in_measurement),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_estimate   (out_estimate),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .end_of_test    (end_of_test),
    .fail_count     (fail_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus two long holds so the filter backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      n_recv <= 0;
    end else begin
      if (out_valid && !out_stall) n_recv <= n_recv + 1;
      if (hold_left == 0 && holds_done < 2 && n_recv == 150 + 300 * holds_done) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  task automatic push_measurement(input logic signed [skf_pkg::MEAS_W-1:0] meas);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_measurement <= meas;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    last_meas = meas;
  endtask

  // Drop valid, drain the filter, then write one register.
  task automatic program_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [skf_pkg::CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (n_recv != n_sent) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [skf_pkg::CFG_W-1:0] pick_noise();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom >> $urandom_range(31);
  endfunction

  // Mostly a wandering signal with small noise; some full-range and edge samples.
  function automatic logic signed [skf_pkg::MEAS_W-1:0] pick_measurement(
      input logic signed [skf_pkg::MEAS_W-1:0] prev);
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 35) return 16'($urandom);
    if (sel < 85) begin
      v = prev + int'($urandom_range(64)) - 32;
      return 16'(v);
    end
    case ($urandom_range(3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return -16'sd1;
    endcase
  endfunction

  initial begin
    snd_idle_pct = 16;
    rcv_stall_pct = 50;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset noise (Q = R = 1.0): first step has gain one half, so +1 lands on a half.
    n_settings++;
    push_measurement(16'sd1);
    push_measurement(-16'sd1);
    push_measurement(16'sh7FFF);
    push_measurement(16'sh8000);
    push_measurement(16'sd0);

    // Zero measurement noise: estimate snaps to each measurement.
    program_reg(skf_pkg::CFG_MEAS_NOISE, '0);
    n_settings++;
    push_measurement(16'sh8000);
    push_measurement(16'sh7FFF);
    push_measurement(-16'sd1);

    // Both noises zero: denominator is zero, nothing moves.
    program_reg(skf_pkg::CFG_PROC_NOISE, '0);
    n_settings++;
    push_measurement(16'sd5);
    push_measurement(-16'sd7);

    // Largest noises: predicted covariance saturates.
    program_reg(skf_pkg::CFG_PROC_NOISE, '1);
    program_reg(skf_pkg::CFG_MEAS_NOISE, '1);
    n_settings++;
    push_measurement(16'sh7FFF);
    push_measurement(16'sh7FFF);
    push_measurement(16'sh8000);
    push_measurement(16'sd100);

    program_reg(skf_pkg::CFG_MEAS_NOISE, 32'd1);
    n_settings++;
    push_measurement(16'sd1234);
    push_measurement(16'sh8000);

    // Unused indexes must leave state alone.
    program_reg(CFG_SPARE_LO, 32'h5A5A_A5A5);
    program_reg(CFG_SPARE_HI, 32'hA5A5_5A5A);
    push_measurement(16'sh5555);
    push_measurement(16'shAAAA);

    for (int mode = 0; mode < 3; mode++) begin
      in_valid <= 1'b0;
      while (n_recv != n_sent) @(posedge clk);
      case (mode)
        0: begin snd_idle_pct = 16; rcv_stall_pct = 50; end
        1: begin snd_idle_pct = 50; rcv_stall_pct = 16; end
        default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        program_reg(skf_pkg::CFG_PROC_NOISE, pick_noise());
        program_reg(skf_pkg::CFG_MEAS_NOISE, pick_noise());
        if ($urandom_range(3) == 0) program_reg(CFG_SPARE_LO + 2'($urandom_range(1)), $urandom);
        n_settings++;
        for (int k = 0; k < PHASE_ITEMS; k++) push_measurement(pick_measurement(last_meas));
      end
    end

    in_valid <= 1'b0;
    while (n_recv != n_sent) @(posedge clk);
    repeat (40) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Sent %0d measurements, took %0d estimates, over %0d noise settings",
             n_sent, n_recv, n_settings);
    $display("with zero and full-scale noise, unused indexes and %0d long output holds",
             holds_done);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
